/* rtl/i2cm_pkg.sv */
// Package with phase codes, operation codes and shared types of the I2C register master.
package i2cm_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_START    = 5'd1;
  localparam logic [4:0] PH_DEV      = 5'd2;
  localparam logic [4:0] PH_ACK_DEV  = 5'd3;
  localparam logic [4:0] PH_REGH     = 5'd4;
  localparam logic [4:0] PH_ACK_REGH = 5'd5;
  localparam logic [4:0] PH_REGL     = 5'd6;
  localparam logic [4:0] PH_ACK_REGL = 5'd7;
  localparam logic [4:0] PH_DATA     = 5'd8;
  localparam logic [4:0] PH_ACK_DATA = 5'd9;
  localparam logic [4:0] PH_RSTART   = 5'd10;
  localparam logic [4:0] PH_DEVR     = 5'd11;
  localparam logic [4:0] PH_ACK_DEVR = 5'd12;
  localparam logic [4:0] PH_RPRE     = 5'd13;
  localparam logic [4:0] PH_RECV     = 5'd14;
  localparam logic [4:0] PH_MACK     = 5'd15;
  localparam logic [4:0] PH_STOP     = 5'd16;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam logic [7:0] READ_FLAG = 8'h01;

  typedef struct packed {
    logic [4:0]  phase;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic        scl_level;
    logic [1:0]  held_op;
    logic [7:0]  held_dev;
    logic [15:0] held_reg;
    logic        held_addr_mode;
    logic        error_flag;
  } state_t;

  typedef struct packed {
    logic        start_req;
    logic [1:0]  op;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic        addr_8bit;
    logic [15:0] byte_count;
    logic [7:0]  wdata;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       wdata_request;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       rdata_last;
    logic       done_res;
    logic       nack_error;
  } rsp_t;

endpackage

/* rtl/i2cm_if.sv */
// Valid/ready channel interfaces for the request and result items.
interface i2cm_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [1:0]  op;
  logic [7:0]  dev_addr;
  logic [15:0] reg_addr;
  logic        addr_8bit;
  logic [15:0] byte_count;
  logic [7:0]  wdata;
  logic        sda_in;

  modport source (
    output valid, start_req, op, dev_addr, reg_addr, addr_8bit, byte_count, wdata, sda_in,
    input  ready
  );
  modport sink (
    input  valid, start_req, op, dev_addr, reg_addr, addr_8bit, byte_count, wdata, sda_in,
    output ready
  );
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic       busy_res;
  logic       wdata_request;
  logic [7:0] rdata;
  logic       rdata_valid;
  logic       rdata_last;
  logic       done_res;
  logic       nack_error;

  modport source (
    output valid, scl, sda, busy_res, wdata_request, rdata, rdata_valid, rdata_last,
           done_res, nack_error,
    input  ready
  );
  modport sink (
    input  valid, scl, sda, busy_res, wdata_request, rdata, rdata_valid, rdata_last,
           done_res, nack_error,
    output ready
  );
endinterface

/* rtl/i2cm_step.sv */
// Bus sequencer next-state logic: one delay period of the I2C master per item.
module i2cm_step #(
  parameter int unsigned COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF
) (
  input  i2cm_pkg::state_t        cur,
  input  logic [COUNT_BITS-1:0]   cur_left,
  input  i2cm_pkg::req_t          req,
  output i2cm_pkg::state_t        nxt,
  output logic [COUNT_BITS-1:0]   nxt_left,
  output i2cm_pkg::rsp_t          rsp
);
  import i2cm_pkg::*;

  state_t                s;
  logic [COUNT_BITS-1:0] left;
  logic [3:0]            sub;
  logic                  scl;

  always_comb begin
    s        = cur;
    left     = cur_left;
    rsp      = '0;
    rsp.sda  = 1'b1;
    rsp.busy_res = 1'b1;
    scl      = 1'b1;

    // A request is taken only while idle and only for a defined operation.
    if (cur.phase == PH_IDLE && req.start_req && req.op <= OP_READ) begin
      s.held_op        = req.op;
      s.held_dev       = req.dev_addr;
      s.held_reg       = req.reg_addr;
      s.held_addr_mode = req.addr_8bit;
      left             = req.byte_count[COUNT_BITS-1:0];
      s.error_flag     = 1'b0;
      s.phase          = PH_START;
      s.bit_index      = '0;
    end
    sub = s.bit_index;

    unique case (s.phase)
      PH_START, PH_RSTART: begin
        scl     = (sub == 4'd0) ? cur.scl_level : 1'b1;
        rsp.sda = (sub >= 4'd2) ? 1'b0 : 1'b1;
        if (sub >= 4'd2) begin
          s.bit_index = '0;
          if (s.phase == PH_START) begin
            s.phase      = PH_DEV;
            s.shift_byte = s.held_dev;
          end else begin
            s.phase      = PH_DEVR;
            s.shift_byte = s.held_dev | READ_FLAG;
          end
        end else begin
          s.bit_index = sub + 4'd1;
        end
      end
      PH_DEV, PH_REGH, PH_REGL, PH_DATA, PH_DEVR: begin
        // Data bytes load the write byte on their first period.
        if (s.phase == PH_DATA && sub == 4'd0) begin
          s.shift_byte = req.wdata;
          left         = left - COUNT_BITS'(1);
        end
        scl     = sub[0];
        rsp.sda = |(s.shift_byte & MSB_MASK);
        if (sub[0]) s.shift_byte = {s.shift_byte[6:0], 1'b0};
        if (sub == 4'd15) begin
          s.phase     = s.phase + 5'd1;
          s.bit_index = '0;
        end else begin
          s.bit_index = sub + 4'd1;
        end
      end
      PH_ACK_DEV, PH_ACK_REGH, PH_ACK_REGL, PH_ACK_DATA, PH_ACK_DEVR: begin
        scl     = (sub == 4'd1);
        rsp.sda = 1'b1;
        if (sub == 4'd1 && req.sda_in) s.error_flag = 1'b1;
        if (sub < 4'd2) begin
          s.bit_index = sub + 4'd1;
        end else begin
          s.bit_index = '0;
          if (s.error_flag) begin
            s.phase = PH_STOP;
          end else if (s.phase == PH_ACK_DEV) begin
            if (s.held_op == OP_PROBE) begin
              s.phase = PH_STOP;
            end else if (s.held_addr_mode) begin
              s.phase      = PH_REGL;
              s.shift_byte = s.held_reg[7:0];
            end else begin
              s.phase      = PH_REGH;
              s.shift_byte = s.held_reg[15:8];
            end
          end else if (s.phase == PH_ACK_REGH) begin
            s.phase      = PH_REGL;
            s.shift_byte = s.held_reg[7:0];
          end else if (s.phase == PH_ACK_DEVR) begin
            s.phase = PH_RPRE;
          end else if (s.phase == PH_ACK_REGL && s.held_op == OP_READ) begin
            s.phase = PH_RSTART;
          end else if (s.held_op == OP_WRITE && left != '0) begin
            s.phase           = PH_DATA;
            rsp.wdata_request = 1'b1;
          end else begin
            s.phase = PH_STOP;
          end
        end
      end
      PH_RPRE: begin
        scl          = 1'b0;
        rsp.sda      = 1'b1;
        s.phase      = PH_RECV;
        s.bit_index  = '0;
        s.shift_byte = '0;
      end
      PH_RECV: begin
        scl     = sub[0];
        rsp.sda = 1'b1;
        if (sub[0]) s.shift_byte = {s.shift_byte[6:0], req.sda_in};
        if (sub == 4'd15) begin
          // A zero-length read still clocks in one byte but does not report it.
          if (left != '0) begin
            rsp.rdata_valid = 1'b1;
            rsp.rdata       = s.shift_byte;
            rsp.rdata_last  = (left == COUNT_BITS'(1));
            left            = left - COUNT_BITS'(1);
          end
          s.phase     = PH_MACK;
          s.bit_index = '0;
        end else begin
          s.bit_index = sub + 4'd1;
        end
      end
      PH_MACK: begin
        scl     = (sub == 4'd1);
        rsp.sda = (sub < 4'd2 && left != '0) ? 1'b0 : 1'b1;
        if (sub < 4'd2) begin
          s.bit_index = sub + 4'd1;
        end else begin
          s.bit_index = '0;
          s.phase     = (left != '0) ? PH_RPRE : PH_STOP;
        end
      end
      PH_STOP: begin
        scl     = (sub == 4'd0) ? cur.scl_level : 1'b1;
        rsp.sda = (sub >= 4'd2) ? 1'b1 : 1'b0;
        if (sub >= 4'd2) begin
          rsp.done_res   = 1'b1;
          rsp.nack_error = s.error_flag;
          s.phase        = PH_IDLE;
          s.bit_index    = '0;
        end else begin
          s.bit_index = sub + 4'd1;
        end
      end
      default: begin
        s.phase      = PH_IDLE;
        s.bit_index  = '0;
        scl          = cur.scl_level;
        rsp.sda      = 1'b1;
        rsp.busy_res = 1'b0;
      end
    endcase

    s.scl_level = scl;
    rsp.scl     = scl;
    nxt         = s;
    nxt_left    = left;
  end

endmodule

/* rtl/i2c_master_register_transfer.sv */
// Top level of the I2C register transfer master with its result skid stage.
//
// Each item on in_ch stands for one bus delay period: it carries the request
// fields (sampled only when a transaction may start), the write byte and the
// SDA level sensed during that period. For every accepted item exactly one
// result item leaves on out_ch, holding the SCL/SDA levels to drive for that
// period together with busy, write-byte request, received byte and done flags.
// The sequencer state updates at the edge that accepts the item, and its result
// goes into the result register, or into the second one while out_ch stalls.
// Throughput is one item per cycle while in_ch.ready is high; the whole period
// step is a single pass of the sequencer next-state logic.
// When out_ch stalls, a second result register absorbs one more item, and
// in_ch.ready drops only while that register is full, so no result is lost
// or repeated. Reset (rst_n low, synchronous) returns the sequencer to idle
// with SCL released and empties both result registers.
module i2c_master_register_transfer #(
  parameter int unsigned COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch
);
  import i2cm_pkg::*;

  state_t                st_r;
  state_t                st_nxt;
  logic [COUNT_BITS-1:0] left_r;
  logic [COUNT_BITS-1:0] left_nxt;
  req_t                  req;
  rsp_t                  rsp;
  rsp_t                  main_r;
  rsp_t                  skid_r;
  logic                  main_valid_r;
  logic                  skid_valid_r;
  logic                  in_fire;
  logic                  out_fire;

  assign req.start_req  = in_ch.start_req;
  assign req.op         = in_ch.op;
  assign req.dev_addr   = in_ch.dev_addr;
  assign req.reg_addr   = in_ch.reg_addr;
  assign req.addr_8bit  = in_ch.addr_8bit;
  assign req.byte_count = in_ch.byte_count;
  assign req.wdata      = in_ch.wdata;
  assign req.sda_in     = in_ch.sda_in;

  i2cm_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cur      (st_r),
    .cur_left (left_r),
    .req      (req),
    .nxt      (st_nxt),
    .nxt_left (left_nxt),
    .rsp      (rsp)
  );

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign out_fire    = main_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '{phase: PH_IDLE, bit_index: 4'd0, shift_byte: 8'd0, scl_level: 1'b1,
                  held_op: OP_PROBE, held_dev: 8'd0, held_reg: 16'd0,
                  held_addr_mode: 1'b1, error_flag: 1'b0};
      left_r <= '0;
    end else if (in_fire) begin
      st_r   <= st_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!main_valid_r || out_fire) begin
        if (skid_valid_r) begin
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_fire) begin
      main_r <= skid_valid_r ? skid_r : rsp;
    end
    if (in_fire && main_valid_r && !out_fire) begin
      skid_r <= rsp;
    end
  end

  assign out_ch.valid         = main_valid_r;
  assign out_ch.scl           = main_r.scl;
  assign out_ch.sda           = main_r.sda;
  assign out_ch.busy_res      = main_r.busy_res;
  assign out_ch.wdata_request = main_r.wdata_request;
  assign out_ch.rdata         = main_r.rdata;
  assign out_ch.rdata_valid   = main_r.rdata_valid;
  assign out_ch.rdata_last    = main_r.rdata_last;
  assign out_ch.done_res      = main_r.done_res;
  assign out_ch.nack_error    = main_r.nack_error;

endmodule
